// File: rtl/midpoint_ellipse_rasterizer_core_defines.svh
// Assertion macros used by the rasterizer sequencer (mer_ctrl).
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_CORE_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MER_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MER_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MER_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define MER_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/mer_pkg.sv
`default_nettype none
package mer_pkg;

    // datapath micro-ops
    localparam logic [4:0] OP_NOP  = 5'd0;
    localparam logic [4:0] OP_AA   = 5'd1;
    localparam logic [4:0] OP_BB   = 5'd2;
    localparam logic [4:0] OP_A2B  = 5'd3;
    localparam logic [4:0] OP_INIT = 5'd4;
    localparam logic [4:0] OP_R1A  = 5'd5;
    localparam logic [4:0] OP_R1B  = 5'd6;
    localparam logic [4:0] OP_R1C  = 5'd7;
    localparam logic [4:0] OP_R1D  = 5'd8;
    localparam logic [4:0] OP_R1E  = 5'd9;
    localparam logic [4:0] OP_P1   = 5'd10;
    localparam logic [4:0] OP_P2   = 5'd11;
    localparam logic [4:0] OP_P3   = 5'd12;
    localparam logic [4:0] OP_P4   = 5'd13;
    localparam logic [4:0] OP_P5   = 5'd14;
    localparam logic [4:0] OP_P6   = 5'd15;
    localparam logic [4:0] OP_Q1   = 5'd16;
    localparam logic [4:0] OP_Q2   = 5'd17;
    localparam logic [4:0] OP_Q3   = 5'd18;
    localparam logic [4:0] OP_Q4   = 5'd19;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_TWO  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    typedef struct packed {
        logic       load;
        logic [4:0] op;
        logic [1:0] pt_sel;
    } mer_cmd_t;

    typedef struct packed {
        logic in_r1;
        logic y_zero;
    } mer_stat_t;

endpackage
`default_nettype wire

// File: rtl/mer_job_if.sv
`default_nettype none
interface mer_job_if #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 11
);
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius_x;
    logic [RADIUS_BITS-1:0] radius_y;

    modport source (output valid, action, center_x, center_y, radius_x, radius_y,
                    input ready);
    modport sink   (input valid, action, center_x, center_y, radius_x, radius_y,
                    output ready);
endinterface
`default_nettype wire

// File: rtl/mer_pixel_if.sv
`default_nettype none
interface mer_pixel_if #(
    parameter int COORD_BITS = 12
);
    logic                        valid;
    logic                        ready;
    logic signed [COORD_BITS+1:0] point_x;
    logic signed [COORD_BITS+1:0] point_y;
    logic                        last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface
`default_nettype wire

// File: rtl/mer_ctrl.sv
`default_nettype none
`include "midpoint_ellipse_rasterizer_core_defines.svh"
module mer_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  logic             job_action,
    output logic             job_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             last_point,
    output mer_pkg::mer_cmd_t cmd,
    input  mer_pkg::mer_stat_t stat
);
    import mer_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_R1    = 3'd2;
    localparam logic [2:0] S_R2I   = 3'd3;
    localparam logic [2:0] S_R2    = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] phase_reg, phase_next;

    assign job_ready  = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_EMIT);
    assign last_point = (k_reg == 2'd3) && stat.y_zero;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 3'd1;
        k_next     = k_reg;
        phase_next = phase_reg;
        cmd.load   = 1'b0;
        cmd.op     = OP_NOP;
        cmd.pt_sel = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = 3'd0;
                if (job_valid)
                begin
                    if (!job_action)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_START;
                        phase_next = PH_ONE;
                    end
                    else if (phase_reg == PH_ONE)
                        state_next = S_R1;
                    else if (phase_reg == PH_TWO)
                        state_next = S_R2;
                end
            end
            S_START:
            begin
                case (cnt_reg)
                    3'd0: cmd.op = OP_AA;
                    3'd1: cmd.op = OP_BB;
                    3'd2: cmd.op = OP_A2B;
                    default:
                    begin
                        cmd.op     = OP_INIT;
                        state_next = S_EMIT;
                        k_next     = 2'd0;
                    end
                endcase
            end
            S_R1:
            begin
                case (cnt_reg)
                    3'd0: cmd.op = OP_R1A;
                    3'd1: cmd.op = OP_R1B;
                    3'd2: cmd.op = OP_R1C;
                    3'd3: cmd.op = OP_R1D;
                    default:
                    begin
                        if (stat.in_r1)
                        begin
                            cmd.op     = OP_R1E;
                            state_next = S_EMIT;
                            k_next     = 2'd0;
                        end
                        else
                        begin
                            state_next = S_R2I;
                            phase_next = PH_TWO;
                            cnt_next   = 3'd0;
                        end
                    end
                endcase
            end
            S_R2I:
            begin
                case (cnt_reg)
                    3'd0: cmd.op = OP_P1;
                    3'd1: cmd.op = OP_P2;
                    3'd2: cmd.op = OP_P3;
                    3'd3: cmd.op = OP_P4;
                    3'd4: cmd.op = OP_P5;
                    default:
                    begin
                        cmd.op     = OP_P6;
                        state_next = S_R2;
                        cnt_next   = 3'd0;
                    end
                endcase
            end
            S_R2:
            begin
                case (cnt_reg)
                    3'd0: cmd.op = OP_Q1;
                    3'd1: cmd.op = OP_Q2;
                    3'd2: cmd.op = OP_Q3;
                    default:
                    begin
                        cmd.op     = OP_Q4;
                        state_next = S_EMIT;
                        k_next     = 2'd0;
                    end
                endcase
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    k_next = k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        state_next = S_IDLE;
                        if (stat.y_zero)
                            phase_next = PH_DONE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 3'd0;
            k_reg     <= 2'd0;
            phase_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            phase_reg <= phase_next;
        end
    end

    `MER_ASSERT_IMPLY(a_emit_has_phase, clk, rst_n, state_reg == S_EMIT, phase_reg != PH_IDLE, "emit without a live ellipse")
    `MER_ASSERT_IMPLY(a_r2_phase, clk, rst_n, state_reg == S_R2, phase_reg == PH_TWO, "region two step outside region two")
    `MER_ASSERT_NEXT(a_last_done, clk, rst_n, out_valid && out_ready && last_point, (phase_reg == PH_DONE) && (state_reg == S_IDLE), "final point did not finish ellipse")
    `MER_ASSERT_NEXT(a_start_seq, clk, rst_n, job_valid && job_ready && !job_action, (state_reg == S_START) && (phase_reg == PH_ONE), "start request not loaded")
endmodule
`default_nettype wire

// File: rtl/mer_datapath.sv
`default_nettype none
module mer_datapath #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 11
) (
    input  logic                          clk,
    input  mer_pkg::mer_cmd_t             cmd,
    output mer_pkg::mer_stat_t            stat,
    input  logic [COORD_BITS-1:0]         center_x,
    input  logic [COORD_BITS-1:0]         center_y,
    input  logic [RADIUS_BITS-1:0]        radius_x,
    input  logic [RADIUS_BITS-1:0]        radius_y,
    output logic signed [COORD_BITS+1:0]  point_x,
    output logic signed [COORD_BITS+1:0]  point_y
);
    import mer_pkg::*;

    localparam int R   = RADIUS_BITS;
    localparam int OW  = COORD_BITS + 2;
    localparam int SQW = 2 * R;
    localparam int MBW = 2 * R + 2;
    localparam int PW  = SQW + MBW;
    localparam int DW  = 4 * R + 6;

    logic [COORD_BITS-1:0] cx_reg, cy_reg;
    logic [R-1:0]          ra_reg, rb_reg, ox_reg, oy_reg;
    logic [SQW-1:0]        a2_reg, b2_reg;
    logic [PW-1:0]         p_reg;
    logic [DW-1:0]         t_reg, dec_reg;
    logic                  r1_reg;

    logic [SQW-1:0] mul_a;
    logic [MBW-1:0] mul_b;
    logic [PW-1:0]  prod;
    logic [R:0]     ox1, oy2m1, tx;
    logic [R+1:0]   ox2p3;
    logic [R-1:0]   oym1, ty;
    logic [DW-1:0]  pext, a2x, b2x;
    logic           neg;
    logic [OW-1:0]  cxw, cyw, oxw, oyw;

    assign ox1   = {1'b0, ox_reg} + (R+1)'(1);
    assign oy2m1 = {oy_reg, 1'b0} - (R+1)'(1);
    assign tx    = {ox_reg, 1'b0} + (R+1)'(1);
    assign ox2p3 = {1'b0, ox_reg, 1'b0} + (R+2)'(3);
    assign oym1  = oy_reg - R'(1);
    // (y-1)^2 wraps to 1 at y = 0
    assign ty    = (oy_reg == '0) ? R'(1) : oym1;

    assign pext = DW'(p_reg);
    assign a2x  = DW'(a2_reg);
    assign b2x  = DW'(b2_reg);
    assign neg  = dec_reg[DW-1];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_AA:  begin mul_a = SQW'(ra_reg); mul_b = MBW'(ra_reg); end
            OP_BB:  begin mul_a = SQW'(rb_reg); mul_b = MBW'(rb_reg); end
            OP_A2B: begin mul_a = a2_reg; mul_b = MBW'(rb_reg); end
            OP_R1A: begin mul_a = b2_reg; mul_b = MBW'(ox1); end
            OP_R1B: begin mul_a = a2_reg; mul_b = MBW'(oy2m1); end
            OP_R1C: begin mul_a = b2_reg; mul_b = MBW'(ox2p3); end
            OP_R1D: begin mul_a = a2_reg; mul_b = MBW'(oym1); end
            OP_P1:  begin mul_a = SQW'(tx); mul_b = MBW'(tx); end
            OP_P2:  begin mul_a = b2_reg; mul_b = p_reg[MBW-1:0]; end
            OP_P3:  begin mul_a = SQW'(ty); mul_b = MBW'(ty); end
            OP_P4:  begin mul_a = a2_reg; mul_b = p_reg[MBW-1:0]; end
            OP_P5:  begin mul_a = a2_reg; mul_b = MBW'(b2_reg); end
            OP_Q1:  begin mul_a = b2_reg; mul_b = MBW'(ox1); end
            OP_Q2:  begin mul_a = a2_reg; mul_b = MBW'(oy_reg); end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
            ra_reg <= radius_x;
            rb_reg <= radius_y;
            ox_reg <= '0;
            oy_reg <= radius_y;
        end
        case (cmd.op)
            OP_AA:   a2_reg <= prod[SQW-1:0];
            OP_BB:   b2_reg <= prod[SQW-1:0];
            OP_A2B:  p_reg <= prod;
            OP_INIT: dec_reg <= (b2x << 2) - (pext << 2) + a2x;
            OP_R1A:  p_reg <= prod;
            OP_R1B:  t_reg <= DW'(prod);
            OP_R1C:
            begin
                r1_reg <= (oy_reg != '0) && ((pext << 1) < t_reg);
                p_reg  <= prod;
            end
            OP_R1D:  t_reg <= DW'(prod);
            OP_R1E:
            begin
                dec_reg <= dec_reg + (pext << 2) - (neg ? '0 : (t_reg << 3));
                ox_reg  <= ox_reg + R'(1);
                if (!neg)
                    oy_reg <= oym1;
            end
            OP_P1:   p_reg <= prod;
            OP_P2:   t_reg <= DW'(prod);
            OP_P3:   p_reg <= prod;
            OP_P4:
            begin
                dec_reg <= t_reg;
                p_reg   <= prod;
            end
            OP_P5:
            begin
                dec_reg <= dec_reg + (pext << 2);
                p_reg   <= prod;
            end
            OP_P6:   dec_reg <= dec_reg - (pext << 2);
            OP_Q1:   p_reg <= prod;
            OP_Q2:   t_reg <= DW'(prod);
            // 4*a^2*(3-2y)
            OP_Q3:   t_reg <= (a2x << 3) + (a2x << 2) - (t_reg << 3);
            OP_Q4:
            begin
                dec_reg <= dec_reg + t_reg + (neg ? (pext << 3) : '0);
                if (neg)
                    ox_reg <= ox_reg + R'(1);
                oy_reg <= oym1;
            end
            default: ;
        endcase
    end

    assign stat.in_r1  = r1_reg;
    assign stat.y_zero = (oy_reg == '0);

    assign cxw = OW'(cx_reg);
    assign cyw = OW'(cy_reg);
    assign oxw = OW'(ox_reg);
    assign oyw = OW'(oy_reg);

    // order: (+x,+y) (-x,+y) (-x,-y) (+x,-y)
    assign point_x = (cmd.pt_sel[0] ^ cmd.pt_sel[1]) ? (cxw - oxw) : (cxw + oxw);
    assign point_y = cmd.pt_sel[1] ? (cyw - oyw) : (cyw + oyw);
endmodule
`default_nettype wire

// File: rtl/midpoint_ellipse_rasterizer_core.sv
`default_nettype none
// Channel  Role    Carries
// job      sink    action, center_x, center_y, radius_x, radius_y
// pixel    source  point_x, point_y, last_point
//
// One request at a time; one shared multiplier does all squared-radius products.
// Every request spends its accept cycle in idle; a step while idle or done ends there.
// Start: multiply/add steps AA, BB, A2B and INIT, then 4 points. Region-one step: R1A to R1E + 4 points.
// Region-two step: Q1 to Q4 + 4 points; the step that leaves region one takes
// the region-one test R1A to R1D, reseed steps P1 to P6 and then Q1 to Q4 before its points.
// Each point waits in place while pixel.ready is low; job.ready is low until done.
// rst_n is asynchronous and clears the sequencer and ellipse phase only.
module midpoint_ellipse_rasterizer_core #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 11
) (
    input  logic        clk,
    input  logic        rst_n,
    mer_job_if.sink     job,
    mer_pixel_if.source pixel
);
    import mer_pkg::*;

    mer_cmd_t  cmd;
    mer_stat_t stat;

    // sequencer: owns phase, micro-op order and point index
    mer_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job.valid),
        .job_action (job.action),
        .job_ready  (job.ready),
        .out_valid  (pixel.valid),
        .out_ready  (pixel.ready),
        .last_point (pixel.last_point),
        .cmd        (cmd),
        .stat       (stat)
    );

    // held geometry, offsets, decision term and the multiplier
    mer_datapath #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .stat     (stat),
        .center_x (job.center_x),
        .center_y (job.center_y),
        .radius_x (job.radius_x),
        .radius_y (job.radius_y),
        .point_x  (pixel.point_x),
        .point_y  (pixel.point_y)
    );
endmodule
`default_nettype wire

// File: tb/midpoint_ellipse_rasterizer_core_tb.sv
`timescale 1ns / 100ps
module midpoint_ellipse_rasterizer_core_tb;
    import mer_pkg::*;

    // action codes on the job channel
    localparam bit ACT_START = 1'b0;
    localparam bit ACT_STEP  = 1'b1;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 500;

    typedef struct {
        bit          action;
        logic [11:0] cx;
        logic [11:0] cy;
        logic [10:0] rx;
        logic [10:0] ry;
    } job_t;

    typedef struct {
        logic signed [13:0] x;
        logic signed [13:0] y;
        logic               last;
    } pixel_t;

    logic clk;
    logic rst_n;
    mer_job_if   job_if ();
    mer_pixel_if pix_if ();

    midpoint_ellipse_rasterizer_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .job   (job_if),
        .pixel (pix_if)
    );

    // pixels still owed by the core, oldest first
    pixel_t pixel_q[$];
    int     errors;
    int     cycles;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_len;
    logic   holding;
    event   hold_go;

    // predictor copy of the tracer state
    logic [10:0] tr_ox, tr_oy;
    logic [63:0] tr_dec;
    logic [1:0]  tr_phase;
    logic [11:0] tr_cx, tr_cy;
    logic [10:0] tr_rx, tr_ry;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Push the four mirrored points of the current offset.
    function void queue_quad();
        pixel_t p;
        logic   fin;
        logic [13:0] xp, xm, yp, ym;
        fin = (tr_oy == 11'd0);
        xp = 14'(32'(tr_cx) + 32'(tr_ox));
        xm = 14'(32'(tr_cx) - 32'(tr_ox));
        yp = 14'(32'(tr_cy) + 32'(tr_oy));
        ym = 14'(32'(tr_cy) - 32'(tr_oy));
        p.last = 1'b0;
        p.x = xp; p.y = yp; pixel_q.push_back(p);
        p.x = xm; p.y = yp; pixel_q.push_back(p);
        p.x = xm; p.y = ym; pixel_q.push_back(p);
        p.x = xp; p.y = ym; p.last = fin; pixel_q.push_back(p);
        if (fin)
            tr_phase = PH_DONE;
    endfunction

    // Advance the midpoint tracer by one accepted request.
    function void trace_ellipse(input job_t j);
        logic [63:0] a2, b2, x, y, tx, ty, vert;
        if (j.action == ACT_START)
        begin
            tr_cx = j.cx; tr_cy = j.cy; tr_rx = j.rx; tr_ry = j.ry;
            a2 = 64'(tr_rx) * 64'(tr_rx);
            b2 = 64'(tr_ry) * 64'(tr_ry);
            tr_ox = 11'd0;
            tr_oy = tr_ry;
            tr_dec = 64'd4 * b2 - 64'd4 * a2 * 64'(tr_ry) + a2;
            tr_phase = PH_ONE;
            queue_quad();
            return;
        end
        if (tr_phase != PH_ONE && tr_phase != PH_TWO)
            return;
        a2 = 64'(tr_rx) * 64'(tr_rx);
        b2 = 64'(tr_ry) * 64'(tr_ry);
        x = 64'(tr_ox);
        y = 64'(tr_oy);
        if (tr_phase == PH_ONE)
        begin
            if (tr_oy != 11'd0 && 64'd2 * b2 * (x + 64'd1) < a2 * (64'd2 * y - 64'd1))
            begin
                if (tr_dec[63])
                    tr_dec = tr_dec + 64'd4 * b2 * (64'd2 * x + 64'd3);
                else
                begin
                    tr_dec = tr_dec + 64'd4 * b2 * (64'd2 * x + 64'd3)
                             - 64'd8 * a2 * (y - 64'd1);
                    tr_oy = tr_oy - 11'd1;
                end
                tr_ox = tr_ox + 11'd1;
                queue_quad();
                return;
            end
            // leaving region one: reseed decision, then take a region-two step
            tx = 64'd2 * x + 64'd1;
            ty = y - 64'd1;
            tr_dec = b2 * tx * tx + 64'd4 * a2 * ty * ty - 64'd4 * a2 * b2;
            tr_phase = PH_TWO;
        end
        vert = 64'd12 * a2 - 64'd8 * a2 * y;
        if (tr_dec[63])
        begin
            tr_dec = tr_dec + 64'd8 * b2 * (x + 64'd1) + vert;
            tr_ox = tr_ox + 11'd1;
        end
        else
            tr_dec = tr_dec + vert;
        tr_oy = tr_oy - 11'd1;
        queue_quad();
    endfunction

    // Offer one request, with optional idle gap before it; valid stays high
    // after acceptance so back-to-back requests never toggle it in one step.
    task automatic send_job(input job_t j);
        if ($urandom_range(99) < send_idle_pct)
        begin
            job_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        job_if.valid    <= 1'b1;
        job_if.action   <= j.action;
        job_if.center_x <= j.cx;
        job_if.center_y <= j.cy;
        job_if.radius_x <= j.rx;
        job_if.radius_y <= j.ry;
        do
            @(posedge clk);
        while (!job_if.ready);
        trace_ellipse(j);
    endtask

    task automatic send_start(input int cx, input int cy, input int rx, input int ry);
        job_t j;
        j.action = ACT_START;
        j.cx = 12'(cx); j.cy = 12'(cy); j.rx = 11'(rx); j.ry = 11'(ry);
        send_job(j);
    endtask

    task automatic send_steps(input int n);
        job_t j;
        j.action = ACT_STEP;
        repeat (n)
        begin
            j.cx = 12'($urandom); j.cy = 12'($urandom);
            j.rx = 11'($urandom); j.ry = 11'($urandom);
            send_job(j);
        end
    endtask

    // Pixel sink: check each accepted point, then decide next ready.
    always @(posedge clk)
    begin
        pixel_t e;
        if (rst_n && pix_if.valid && pix_if.ready)
        begin
            if (pixel_q.size() == 0)
            begin
                $error("unexpected pixel x=%0d y=%0d", pix_if.point_x, pix_if.point_y);
                errors++;
            end
            else
            begin
                e = pixel_q.pop_front();
                if (pix_if.point_x !== e.x)
                begin
                    $error("point_x expected %0d actual %0d", e.x, pix_if.point_x);
                    errors++;
                end
                if (pix_if.point_y !== e.y)
                begin
                    $error("point_y expected %0d actual %0d", e.y, pix_if.point_y);
                    errors++;
                end
                if (pix_if.last_point !== e.last)
                begin
                    $error("last_point expected %0d actual %0d", e.last,
                           pix_if.last_point);
                    errors++;
                end
            end
        end
        pix_if.ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long receiver hold-off, counted here so the sender keeps pushing.
    initial
    begin
        holding = 1'b0;
        forever
        begin
            @(hold_go);
            @(posedge clk);
            holding <= 1'b1;
            repeat (hold_len) @(posedge clk);
            holding <= 1'b0;
        end
    end

    task automatic test_idle_step();
        // nothing loaded yet: steps must be dropped silently
        send_steps(2);
    endtask

    task automatic test_unit_circle();
        send_start(0, 0, 1, 1);
        send_steps(5);   // runs past done, tail steps are dropped
    endtask

    task automatic test_zero_radii();
        send_start(100, 200, 5, 0);   // flat: four copies of the center point, straight to done
        send_steps(1);
        send_start(4095, 0, 0, 3);    // no region one, walk down x = 0
        send_steps(4);
        send_start(0, 0, 0, 0);
    endtask

    task automatic test_extremes();
        send_start(4095, 4095, 2047, 2047);
        send_steps(3);
        send_start(0, 4095, 2047, 1);     // wide and flat
        send_steps(3);
        send_start(2048, 2047, 1, 2047);  // tall and thin
        send_steps(3);
    endtask

    task automatic test_restart();
        send_start(300, 300, 6, 4);
        send_steps(3);
        send_start(10, 20, 3, 7);         // abandon mid-trace
        send_steps(14);
    endtask

    task automatic test_backpressure();
        send_start(1000, 1000, 9, 9);
        hold_len = 400;
        -> hold_go;
        send_steps(8);
    endtask

    // Mostly started ellipses with random geometry and step counts, plus some noise requests.
    task automatic test_random(input int n);
        job_t j;
        int   sent, steps, rx, ry;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(99) < 10)
            begin
                j.action = 1'($urandom_range(1));
                j.cx = 12'($urandom); j.cy = 12'($urandom);
                j.rx = 11'($urandom); j.ry = 11'($urandom);
                send_job(j);
                sent++;
            end
            else
            begin
                if ($urandom_range(99) < 88)
                begin
                    rx = $urandom_range(0, 12);
                    ry = $urandom_range(0, 12);
                    steps = $urandom_range(1, 2 * (rx + ry) + 4);
                end
                else
                begin
                    rx = $urandom_range(0, 2047);
                    ry = $urandom_range(0, 2047);
                    steps = $urandom_range(1, 30);
                end
                send_start($urandom_range(0, 4095), $urandom_range(0, 4095), rx, ry);
                send_steps(steps);
                sent += steps + 1;
            end
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_len = 0;
        rst_n = 1'b0;
        job_if.valid = 1'b0;
        job_if.action = ACT_START;
        job_if.center_x = '0;
        job_if.center_y = '0;
        job_if.radius_x = '0;
        job_if.radius_y = '0;
        pix_if.ready = 1'b0;
        tr_ox = '0; tr_oy = '0; tr_dec = '0; tr_phase = PH_IDLE;
        tr_cx = '0; tr_cy = '0; tr_rx = '0; tr_ry = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_step();
        test_unit_circle();
        test_zero_radii();
        test_extremes();
        test_restart();
        test_backpressure();

        test_random(RANDOM_ITEMS / 4);
        send_idle_pct = 68;
        test_random(RANDOM_ITEMS / 4);
        send_idle_pct = 0;
        recv_stall_pct = 68;
        test_random(RANDOM_ITEMS / 4);
        send_idle_pct = 8;
        recv_stall_pct = 8;
        test_random(RANDOM_ITEMS / 4);

        job_if.valid <= 1'b0;
        recv_stall_pct = 0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
